>>> sv/ecbp_pkg.sv
package ecbp_pkg;

    localparam int NAME_DEPTH_DEF = 256;

    // parse phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_COUNT = 2'd1;
    localparam logic [1:0] PH_DATA  = 2'd2;

    // framed command kinds
    localparam logic [2:0] KIND_MODE  = 3'd0;
    localparam logic [2:0] KIND_TEMP  = 3'd1;
    localparam logic [2:0] KIND_DONE  = 3'd2;
    localparam logic [2:0] KIND_FAN   = 3'd3;
    localparam logic [2:0] KIND_LIGHT = 3'd4;

    // flag bit positions
    localparam int FLG_LIGHT  = 0;
    localparam int FLG_TOGGLE = 1;
    localparam int FLG_DONE   = 2;
    localparam int FLG_ERR    = 3;

    // legacy byte codes
    localparam logic [7:0] LEG_MODE_END  = 8'd4;
    localparam logic [7:0] LEG_DONE_SET  = 8'd4;
    localparam logic [7:0] LEG_DONE_CLR  = 8'd5;
    localparam logic [7:0] LEG_LIGHT_ON  = 8'd6;
    localparam logic [7:0] LEG_LIGHT_OFF = 8'd7;
    localparam logic [7:0] LEG_TOGGLE    = 8'd8;
    localparam logic [7:0] LEG_NOP       = 8'd9;
    localparam logic [7:0] LEG_TEMP_LO   = 8'd10;
    localparam logic [7:0] LEG_FAN_LO    = 8'd100;
    localparam logic [7:0] LEG_END       = 8'd105;
    localparam logic [7:0] FRAME_START   = 8'd250;

    // register indexes on the config bus (paddr[3:2])
    localparam logic [1:0] REG_MIN_TEMP   = 2'd0;
    localparam logic [1:0] REG_MAX_TEMP   = 2'd1;
    localparam logic [1:0] REG_MODE_LIMIT = 2'd2;

    localparam logic [7:0] MIN_TEMP_RST   = 8'd0;
    localparam logic [7:0] MAX_TEMP_RST   = 8'd100;
    localparam logic [7:0] MODE_LIMIT_RST = 8'd4;

    localparam int OUT_W = 56;

    typedef struct packed {
        logic [7:0] min_temp;
        logic [7:0] max_temp;
        logic [7:0] mode_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] mode;
        logic [7:0] temp;
        logic [7:0] fan;
        logic [3:0] flags;
        logic [7:0] old_mode;
        logic [7:0] last_idx;
        logic       used;
    } t_status;

    typedef struct packed {
        logic       wr_en;
        logic [7:0] idx;
        logic [7:0] data;
        logic       clr;
        logic [8:0] clr_from;
    } t_name_req;

    // (s*255)/4 for the legacy fan bytes 100..104
    function automatic logic [7:0] fan_scale(input logic [2:0] s);
        logic [7:0] r;
        case (s)
            3'd0:    r = 8'd0;
            3'd1:    r = 8'd63;
            3'd2:    r = 8'd127;
            3'd3:    r = 8'd191;
            3'd4:    r = 8'd255;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

endpackage

>>> sv/ecbp_ram.sv
module ecbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/ecbp_cfg.sv
module ecbp_cfg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output ecbp_pkg::t_cfg     o_cfg
);

    logic [7:0] r_min_temp;
    logic [7:0] r_max_temp;
    logic [7:0] r_mode_limit;
    logic       wr;

    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_temp   <= ecbp_pkg::MIN_TEMP_RST;
            r_max_temp   <= ecbp_pkg::MAX_TEMP_RST;
            r_mode_limit <= ecbp_pkg::MODE_LIMIT_RST;
        end else if (wr) begin
            case (paddr[3:2])
                ecbp_pkg::REG_MIN_TEMP:   r_min_temp   <= pwdata[7:0];
                ecbp_pkg::REG_MAX_TEMP:   r_max_temp   <= pwdata[7:0];
                ecbp_pkg::REG_MODE_LIMIT: r_mode_limit <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ecbp_pkg::REG_MIN_TEMP:   prdata = {24'd0, r_min_temp};
            ecbp_pkg::REG_MAX_TEMP:   prdata = {24'd0, r_max_temp};
            ecbp_pkg::REG_MODE_LIMIT: prdata = {24'd0, r_mode_limit};
            default:                  prdata = 32'd0;
        endcase
    end

    assign o_cfg.min_temp   = r_min_temp;
    assign o_cfg.max_temp   = r_max_temp;
    assign o_cfg.mode_limit = r_mode_limit;

endmodule

>>> sv/ecbp_core.sv
module ecbp_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_first,
    input  ecbp_pkg::t_cfg        i_cfg,
    output ecbp_pkg::t_status     o_status,
    output ecbp_pkg::t_name_req   o_name_req
);

    logic [1:0] r_phase, n_phase;
    logic [2:0] r_kind, n_kind;
    logic [7:0] r_count, n_count;
    logic [7:0] r_pidx, n_pidx;
    logic [7:0] r_mode, n_mode;
    logic [7:0] r_temp, n_temp;
    logic [7:0] r_fan, n_fan;
    logic [3:0] r_flags, n_flags;
    logic [7:0] r_old_mode, n_old_mode;
    logic [7:0] r_last_idx, n_last_idx;

    logic [1:0] ph;
    logic       last;
    logic       used;
    logic [7:0] fan_off;
    logic [7:0] v;

    assign v       = i_byte;
    assign fan_off = v - ecbp_pkg::LEG_FAN_LO;

    always_comb begin
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_count    = r_count;
        n_pidx     = r_pidx;
        n_mode     = r_mode;
        n_temp     = r_temp;
        n_fan      = r_fan;
        n_flags    = r_flags;
        n_old_mode = r_old_mode;
        n_last_idx = r_last_idx;
        used       = 1'b0;
        o_name_req = '0;
        ph         = i_first ? ecbp_pkg::PH_IDLE : r_phase;
        last       = (r_pidx == (r_count - 8'd1));
        if (i_step) begin
            if (ph == ecbp_pkg::PH_COUNT) begin
                n_count = v;
                n_pidx  = 8'd0;
                n_phase = (v == 8'd0) ? ecbp_pkg::PH_IDLE : ecbp_pkg::PH_DATA;
                used    = 1'b1;
            end else if (ph == ecbp_pkg::PH_DATA) begin
                used   = 1'b1;
                n_pidx = r_pidx + 8'd1;
                case (r_kind)
                    ecbp_pkg::KIND_MODE: begin
                        if (v < i_cfg.mode_limit) begin
                            if (v == 8'd0) begin
                                n_flags[ecbp_pkg::FLG_ERR] = 1'b1;
                                n_old_mode = r_mode;
                            end
                            n_mode = v;
                        end
                    end
                    ecbp_pkg::KIND_TEMP: begin
                        if (i_cfg.min_temp < v && v < i_cfg.max_temp) begin
                            n_temp = v;
                        end
                    end
                    ecbp_pkg::KIND_DONE: begin
                        if (v == 8'd0) n_flags[ecbp_pkg::FLG_DONE] = 1'b0;
                        else if (v == 8'd1) n_flags[ecbp_pkg::FLG_DONE] = 1'b1;
                    end
                    ecbp_pkg::KIND_FAN: begin
                        n_fan = v;
                    end
                    ecbp_pkg::KIND_LIGHT: begin
                        if (v == 8'd0) n_flags[ecbp_pkg::FLG_LIGHT] = 1'b1;
                        else if (v == 8'd1) n_flags[ecbp_pkg::FLG_LIGHT] = 1'b0;
                        else if (v == 8'd2) n_flags[ecbp_pkg::FLG_TOGGLE] = 1'b1;
                    end
                    default: begin
                        // name character; the tail clear runs in the top level
                        o_name_req.wr_en    = 1'b1;
                        o_name_req.idx      = r_pidx;
                        o_name_req.data     = v;
                        o_name_req.clr      = last;
                        o_name_req.clr_from = {1'b0, r_pidx} + 9'd1;
                        if (last) n_last_idx = r_pidx;
                    end
                endcase
                if (last || (({1'b0, r_pidx} + 9'd1) >= {1'b0, r_count})) begin
                    n_phase = ecbp_pkg::PH_IDLE;
                end
            end else begin
                n_phase = ecbp_pkg::PH_IDLE;
                if (v < ecbp_pkg::LEG_END) begin
                    used = (v != ecbp_pkg::LEG_NOP);
                    if (v < ecbp_pkg::LEG_MODE_END) begin
                        if (v == 8'd0) begin
                            n_flags[ecbp_pkg::FLG_ERR] = 1'b1;
                            n_old_mode = r_mode;
                        end
                        n_mode = v;
                    end else if (v < ecbp_pkg::LEG_TEMP_LO) begin
                        case (v)
                            ecbp_pkg::LEG_DONE_SET:  n_flags[ecbp_pkg::FLG_DONE]   = 1'b1;
                            ecbp_pkg::LEG_DONE_CLR:  n_flags[ecbp_pkg::FLG_DONE]   = 1'b0;
                            ecbp_pkg::LEG_LIGHT_ON:  n_flags[ecbp_pkg::FLG_LIGHT]  = 1'b1;
                            ecbp_pkg::LEG_LIGHT_OFF: n_flags[ecbp_pkg::FLG_LIGHT]  = 1'b0;
                            ecbp_pkg::LEG_TOGGLE:    n_flags[ecbp_pkg::FLG_TOGGLE] = 1'b1;
                            default: ;
                        endcase
                    end else if (v < ecbp_pkg::LEG_FAN_LO) begin
                        n_temp = v;
                    end else begin
                        n_fan = ecbp_pkg::fan_scale(fan_off[2:0]);
                    end
                end else if (v >= ecbp_pkg::FRAME_START) begin
                    n_kind  = ~v[2:0];
                    n_phase = ecbp_pkg::PH_COUNT;
                    used    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= ecbp_pkg::PH_IDLE;
            r_kind     <= 3'd0;
            r_count    <= 8'd0;
            r_pidx     <= 8'd0;
            r_mode     <= 8'd0;
            r_temp     <= 8'd0;
            r_fan      <= 8'd0;
            r_flags    <= 4'd0;
            r_old_mode <= 8'd0;
            r_last_idx <= 8'd0;
        end else begin
            r_phase    <= n_phase;
            r_kind     <= n_kind;
            r_count    <= n_count;
            r_pidx     <= n_pidx;
            r_mode     <= n_mode;
            r_temp     <= n_temp;
            r_fan      <= n_fan;
            r_flags    <= n_flags;
            r_old_mode <= n_old_mode;
            r_last_idx <= n_last_idx;
        end
    end

    // values after this step's update
    assign o_status.mode     = n_mode;
    assign o_status.temp     = n_temp;
    assign o_status.fan      = n_fan;
    assign o_status.flags    = n_flags;
    assign o_status.old_mode = n_old_mode;
    assign o_status.last_idx = n_last_idx;
    assign o_status.used     = used;

endmodule

>>> sv/enclosure_command_byte_parser_unit.sv
// Enclosure command byte parser.
// Input stream: one transaction per received byte, or a name store read when
// tuser[0] is set. Output stream: one transaction per input, carrying all
// settings after the update, the read name character and the byte-used flag.
// Settings are in flip-flops; the name store is a single-port-write RAM with
// a registered read.
// A command byte's result is valid the cycle after acceptance; a name read
// passes the RAM read register, then the output register, and no new input is
// taken until its result is registered. Command bytes are taken one per cycle
// while the output is not stalled. After the last name character the store
// tail is zeroed one entry per cycle with the input held off.
// Reset: settings return to their defaults, then a clearing pass zeroes every
// entry of the name store before the first input is taken.
// Config writes over the APB port are accepted at any time.
// Stall: the result waits in the output register; a new input is taken in the
// cycle the waiting result is taken, never while it would be overwritten.
module enclosure_command_byte_parser_unit #(
    parameter int NAME_DEPTH = ecbp_pkg::NAME_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // data_byte[7:0], read_index[15:8]
    input  logic [1:0]  i_s_tuser,   // name_read[0], first_of_frame[1]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // cur_mode[7:0], target_temp[15:8], fan_limit[23:16], light_on_request[24],
    // light_toggle_request[25], print_finished[26], error_recorded[27],
    // error_old_mode[35:28], name_last_index[43:36], name_char[51:44],
    // byte_used[52], zero[55:53]
    output logic [ecbp_pkg::OUT_W-1:0] o_m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = $clog2(NAME_DEPTH);

    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_RDWAIT = 2'd2;

    logic [1:0]     r_state, n_state;
    logic [AW-1:0]  r_clr_addr, n_clr_addr;
    logic           r_rd_oob, n_rd_oob;
    logic           r_ovalid, n_ovalid;
    logic [ecbp_pkg::OUT_W-1:0] r_out, n_out;

    ecbp_pkg::t_cfg      cfg;
    ecbp_pkg::t_status   status;
    ecbp_pkg::t_name_req name_req;

    logic           out_free;
    logic           acc;
    logic           acc_byte;
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_wdata;
    logic           ram_re;
    logic [7:0]     ram_rdata;
    logic [7:0]     nchar;

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign acc        = i_s_tvalid && o_s_tready;
    assign acc_byte   = acc && !i_s_tuser[0];

    ecbp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ecbp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (acc_byte),
        .i_byte     (i_s_tdata[7:0]),
        .i_first    (i_s_tuser[1]),
        .i_cfg      (cfg),
        .o_status   (status),
        .o_name_req (name_req)
    );

    ecbp_ram #(
        .WIDTH (8),
        .DEPTH (NAME_DEPTH)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (i_s_tdata[8+AW-1:8]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        if (r_state == S_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = 8'd0;
        end else begin
            ram_we    = acc_byte && name_req.wr_en
                        && ({1'b0, name_req.idx} < 9'(NAME_DEPTH));
            ram_waddr = name_req.idx[AW-1:0];
            ram_wdata = name_req.data;
        end
    end

    assign ram_re = acc && i_s_tuser[0];
    assign nchar  = r_rd_oob ? 8'd0 : ram_rdata;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_rd_oob   = r_rd_oob;
        n_ovalid   = r_ovalid && !i_m_tready;
        n_out      = r_out;
        case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(NAME_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc && i_s_tuser[0]) begin
                    n_rd_oob = !({1'b0, i_s_tdata[15:8]} < 9'(NAME_DEPTH));
                    n_state  = S_RDWAIT;
                end else if (acc) begin
                    n_ovalid = 1'b1;
                    n_out    = {3'd0, status.used, 8'd0, status.last_idx, status.old_mode,
                                status.flags, status.fan, status.temp, status.mode};
                    // zero the tail of the name after its last character
                    if (name_req.clr && (name_req.clr_from < 9'(NAME_DEPTH))) begin
                        n_clr_addr = name_req.clr_from[AW-1:0];
                        n_state    = S_CLEAR;
                    end
                end
            end
            S_RDWAIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = {3'd0, 1'b0, nchar, status.last_idx, status.old_mode,
                                status.flags, status.fan, status.temp, status.mode};
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_rd_oob   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_rd_oob   <= n_rd_oob;
            r_ovalid   <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_out;

endmodule
